### rtl/core/tps_pkg.sv
// ----------------------------------------------------------------------------
// tps_pkg: shared types and constants for the text punctuation spacer
// Character codes, window size, sequencer states and byte class helpers.
// ----------------------------------------------------------------------------
package tps_pkg;

  localparam int unsigned WIN_BYTES = 6;
  localparam int unsigned WIN_IDX_W = $clog2(WIN_BYTES);
  localparam int unsigned CNT_W     = $clog2(WIN_BYTES + 1);

  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_LT    = 8'h3C;
  localparam logic [7:0] CH_GT    = 8'h3E;
  localparam logic [7:0] CH_B     = 8'h62;
  localparam logic [7:0] CH_R     = 8'h72;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_SEMI  = 8'h3B;
  localparam logic [7:0] CH_COLON = 8'h3A;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_HEAD,
    ST_EMIT,
    ST_DONE
  } tps_state_e;

  function automatic logic is_mark(input logic [7:0] c);
    logic r;
    case (c) inside
      8'h27, 8'h22, 8'h2E, 8'h2C, 8'h28, 8'h29, 8'h21, 8'h3F: r = 1'b1;
      default: r = 1'b0;
    endcase
    return r;
  endfunction

  // whitespace, control bytes BEL..CR, and the two separators
  function automatic logic is_blank(input logic [7:0] c);
    logic r;
    case (c) inside
      CH_SPACE, [8'h07:8'h0D], CH_SEMI, CH_COLON: r = 1'b1;
      default: r = 1'b0;
    endcase
    return r;
  endfunction

endpackage

### rtl/core/text_punctuation_spacer.sv
// ----------------------------------------------------------------------------
// text_punctuation_spacer: byte-serial text cleaner for tokenizing
// Spaces out punctuation, folds whitespace and break tags into one space.
// ----------------------------------------------------------------------------
// Usage:
//   Slave stream: one string byte per word. tdata = in_byte, tlast marks the
//   last byte of a string, tuser marks an empty string (tdata ignored), which
//   also flushes any string still pending.
//   Master stream: one result per word. tdata = out_byte, tlast = string
//   done, tuser[0] = byte valid, tuser[1] = last result of its input word.
//   A string that gives no bytes yields one bare end word (tuser[0] low).
// Sequencing:
//   One word is taken, then s_axis_tready_o stays low while a small
//   sequencer works on it. Each head clean of the six-byte window uses the
//   shared compare unit in ST_HEAD; ST_EMIT then sends each byte it emits
//   (0..3), waiting on the output, and returns to ST_HEAD. A word that only
//   fills the window goes on to ST_DONE; an end of string flushes up to six.
//   One result is held back until the next is known, so the last one can
//   carry its flags; results leave through an output register.
// Reset and stall:
//   Reset empties the window and the output. A stalled receiver freezes the
//   sequencer at its next output word; nothing is lost or repeated.
// ----------------------------------------------------------------------------
module text_punctuation_spacer
  import tps_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_axis_tvalid_i,
  output logic       s_axis_tready_o,
  input  logic [7:0] s_axis_tdata_i,   // [7:0] in_byte
  input  logic       s_axis_tlast_i,   // end_of_string
  input  logic       s_axis_tuser_i,   // [0] empty_string
  output logic       m_axis_tvalid_o,
  input  logic       m_axis_tready_i,
  output logic [7:0] m_axis_tdata_o,   // [7:0] out_byte
  output logic       m_axis_tlast_o,   // string_done
  output logic [1:0] m_axis_tuser_o    // [0] byte_valid, [1] run_last
);

  tps_state_e state_q, state_d;

  logic [7:0]       win_q [WIN_BYTES];
  logic [7:0]       win_d [WIN_BYTES];
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             fin_q, fin_d;
  logic [7:0]       lob_q, lob_d;
  logic             lov_q, lov_d;

  logic [7:0] emit_q [3];
  logic [7:0] emit_d [3];
  logic [1:0] emit_n_q, emit_n_d;
  logic [1:0] emit_idx_q, emit_idx_d;

  logic       held_v_q, held_v_d;
  logic [7:0] held_b_q, held_b_d;

  logic       ov_q;
  logic [7:0] ob_q;
  logic       obv_q, osd_q, orl_q;

  logic       out_load;
  logic [7:0] ld_b;
  logic       ld_bv, ld_sd, ld_rl;
  logic       out_free;
  logic       accept;
  logic       do_clean;

  // head clean unit
  logic [7:0]       cl_list [3];
  logic [1:0]       cl_n;
  logic [2:0]       cl_used;
  logic             last_sp;
  logic             tag4, tag5, tag6;

  assign out_free = !ov_q || m_axis_tready_i;
  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign accept = s_axis_tvalid_i && s_axis_tready_o;
  assign do_clean = fin_q ? (cnt_q != '0) : (cnt_q == CNT_W'(WIN_BYTES));

  always_comb begin
    last_sp = lov_q && (lob_q == CH_SPACE);
    tag4 = (cnt_q >= CNT_W'(4)) && win_q[0] == CH_LT && win_q[1] == CH_B &&
           win_q[2] == CH_R && win_q[3] == CH_GT;
    tag5 = (cnt_q >= CNT_W'(5)) && win_q[0] == CH_LT && win_q[1] == CH_B &&
           win_q[2] == CH_R && win_q[3] == CH_SPACE && win_q[4] == CH_GT;
    tag6 = (cnt_q >= CNT_W'(6)) && win_q[0] == CH_LT && win_q[1] == CH_B &&
           win_q[2] == CH_R && win_q[3] == CH_SPACE && win_q[4] == CH_SLASH &&
           win_q[5] == CH_GT;
    cl_list[0] = win_q[0];
    cl_list[1] = CH_SPACE;
    cl_list[2] = CH_SPACE;
    cl_n = 2'd0;
    cl_used = 3'd1;
    if (is_mark(win_q[0])) begin
      if (!last_sp) begin
        cl_list[0] = CH_SPACE;
        cl_list[1] = win_q[0];
        cl_n = 2'd2;
      end else begin
        cl_n = 2'd1;
      end
      if (cnt_q > CNT_W'(1) && win_q[1] != CH_SPACE) begin
        cl_n = cl_n + 2'd1;
      end
    end else if (is_blank(win_q[0])) begin
      cl_list[0] = CH_SPACE;
      cl_n = last_sp ? 2'd0 : 2'd1;
    end else if (win_q[0] == CH_LT && cnt_q > CNT_W'(4) && win_q[1] == CH_B &&
                 (tag4 || tag5 || tag6)) begin
      cl_list[0] = CH_SPACE;
      cl_n = last_sp ? 2'd0 : 2'd1;
      cl_used = tag4 ? 3'd4 : (tag5 ? 3'd5 : 3'd6);
    end else begin
      cl_n = 2'd1;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: if (accept) state_d = ST_HEAD;
      ST_HEAD: state_d = do_clean ? ST_EMIT : ST_DONE;
      ST_EMIT: if (emit_idx_q == emit_n_q) state_d = ST_HEAD;
      ST_DONE: if (!((held_v_q || fin_q) && !out_free)) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    win_d      = win_q;
    cnt_d      = cnt_q;
    fin_d      = fin_q;
    lob_d      = lob_q;
    lov_d      = lov_q;
    emit_d     = emit_q;
    emit_n_d   = emit_n_q;
    emit_idx_d = emit_idx_q;
    held_v_d   = held_v_q;
    held_b_d   = held_b_q;
    out_load   = 1'b0;
    ld_b       = held_b_q;
    ld_bv      = 1'b1;
    ld_sd      = 1'b0;
    ld_rl      = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          fin_d = s_axis_tlast_i || s_axis_tuser_i;
          if (!s_axis_tuser_i) begin
            win_d[cnt_q[WIN_IDX_W-1:0]] = s_axis_tdata_i;
            cnt_d = cnt_q + CNT_W'(1);
          end
        end
      end
      ST_HEAD: begin
        if (do_clean) begin
          emit_d     = cl_list;
          emit_n_d   = cl_n;
          emit_idx_d = 2'd0;
          if (cl_n != 2'd0) begin
            lob_d = cl_list[cl_n - 2'd1];
            lov_d = 1'b1;
          end
          for (int i = 0; i < WIN_BYTES; i++) begin
            if (i + int'(cl_used) < WIN_BYTES) begin
              win_d[i] = win_q[WIN_IDX_W'(i + int'(cl_used))];
            end
          end
          cnt_d = cnt_q - CNT_W'(cl_used);
        end
      end
      ST_EMIT: begin
        if (emit_idx_q != emit_n_q && (!held_v_q || out_free)) begin
          out_load   = held_v_q;
          held_v_d   = 1'b1;
          held_b_d   = emit_q[emit_idx_q];
          emit_idx_d = emit_idx_q + 2'd1;
        end
      end
      ST_DONE: begin
        if ((held_v_q || fin_q) && out_free) begin
          out_load = 1'b1;
          ld_b     = held_v_q ? held_b_q : 8'h00;
          ld_bv    = held_v_q;
          ld_sd    = fin_q;
          ld_rl    = 1'b1;
          held_v_d = 1'b0;
          if (fin_q) begin
            lob_d = 8'h00;
            lov_d = 1'b0;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      cnt_q    <= '0;
      fin_q    <= 1'b0;
      lob_q    <= 8'h00;
      lov_q    <= 1'b0;
      emit_n_q <= 2'd0;
      emit_idx_q <= 2'd0;
      held_v_q <= 1'b0;
      ov_q     <= 1'b0;
    end else begin
      state_q    <= state_d;
      cnt_q      <= cnt_d;
      fin_q      <= fin_d;
      lob_q      <= lob_d;
      lov_q      <= lov_d;
      emit_n_q   <= emit_n_d;
      emit_idx_q <= emit_idx_d;
      held_v_q   <= held_v_d;
      if (out_load) begin
        ov_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        ov_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    win_q    <= win_d;
    emit_q   <= emit_d;
    held_b_q <= held_b_d;
    if (out_load) begin
      ob_q  <= ld_b;
      obv_q <= ld_bv;
      osd_q <= ld_sd;
      orl_q <= ld_rl;
    end
  end

  assign m_axis_tvalid_o = ov_q;
  assign m_axis_tdata_o  = ob_q;
  assign m_axis_tlast_o  = osd_q;
  assign m_axis_tuser_o  = {orl_q, obv_q};

endmodule
